// ===== rtl/cbbm_pkg.sv =====
// ----------------------------------------------------------------------------
// Contact bounce burst meter package
// Shared constants, codes and types of the burst meter front and back ends.
// ----------------------------------------------------------------------------
package cbbm_pkg;

   // Sizes of the design.
   localparam int CHANNELS    = 4;
   localparam int TIME_BITS   = 48;
   localparam int COUNT_BITS  = 16;
   localparam int CHAN_BITS   = 2;
   localparam int QUIET_BITS  = 24;
   localparam int IDX_BITS    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = 1;
   localparam int QCNT_BITS   = 2;

   localparam logic [QUIET_BITS-1:0] QUIET_RESET = QUIET_BITS'(500000);

   // Input item kinds.
   localparam logic KIND_EDGE = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   // Report kinds.
   localparam logic REPORT_EDGE   = 1'b0;
   localparam logic REPORT_CLOSED = 1'b1;

   // Classified item as it waits in the queue.
   typedef struct packed {
      logic                 edge_en;
      logic [CHAN_BITS-1:0] channel;
      logic                 level;
      logic [TIME_BITS-1:0] now;
   } item_type;

   // One report, without its last flag.
   typedef struct packed {
      logic                  kind;
      logic [CHAN_BITS-1:0]  channel;
      logic                  level;
      logic [TIME_BITS-1:0]  gap;
      logic [COUNT_BITS-1:0] count;
      logic [TIME_BITS-1:0]  burst;
      logic [TIME_BITS-1:0]  longest;
   } report_type;

   // Back end state machine.
   typedef enum logic [1:0] {
      ST_EDGE,
      ST_SCAN,
      ST_FLUSH
   } back_state_type;

endpackage

// ===== rtl/cbbm_front.sv =====
// ----------------------------------------------------------------------------
// Burst meter front end
// Accepts items, classifies them as channel edges or time ticks and holds
// them in a short queue for the back end.
// ----------------------------------------------------------------------------
module cbbm_front
   import cbbm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_kind,
   input  logic [CHAN_BITS-1:0] req_channel,
   input  logic                 req_edge_level,
   input  logic [TIME_BITS-1:0] req_now_us,
   output logic                 head_valid,
   output item_type             head_item,
   input  logic                 head_pop
);

   item_type               queue_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]   fill_ff, fill_in;
   logic                   push;
   logic                   pop;
   item_type               new_item;

   // An edge on a channel that does not exist is handled as a tick.
   always_comb begin
      new_item.edge_en = (req_kind == KIND_EDGE) &&
                         ({1'b0, req_channel} < (CHAN_BITS + 1)'(CHANNELS));
      new_item.channel = req_channel;
      new_item.level   = req_edge_level;
      new_item.now     = req_now_us;
   end

   assign req_ready  = (fill_ff != QCNT_BITS'(QUEUE_DEPTH));
   assign head_valid = (fill_ff != '0);
   assign head_item  = queue_ff[rd_ptr_ff];
   assign push       = req_valid && req_ready;
   assign pop        = head_pop && head_valid;

   // Queue pointers and fill level.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

// ===== rtl/cbbm_back.sv =====
// ----------------------------------------------------------------------------
// Burst meter back end
// Applies the edge of the queue head to its channel, then scans every
// channel for a quiet burst and closes it. Reports leave through an output
// register; one report is held back so that the final one can be flagged.
// ----------------------------------------------------------------------------
module cbbm_back
   import cbbm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [QUIET_BITS-1:0] quiet_time,
   input  logic                  head_valid,
   input  item_type              head_item,
   output logic                  head_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output report_type            rsp_report,
   output logic                  rsp_last
);

   // Per-channel burst state.
   logic [TIME_BITS-1:0]  start_ff   [CHANNELS];
   logic [TIME_BITS-1:0]  latest_ff  [CHANNELS];
   logic [COUNT_BITS-1:0] count_ff   [CHANNELS];
   logic [TIME_BITS-1:0]  longest_ff [CHANNELS];
   logic                  level_ff   [CHANNELS];

   back_state_type        state_ff, state_in;
   logic [IDX_BITS-1:0]   idx_ff, idx_in;
   report_type            pend_ff, pend_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic                  rsp_valid_ff;
   report_type            rsp_report_ff;
   logic                  rsp_last_ff;

   logic [IDX_BITS-1:0]   addr;
   logic [TIME_BITS-1:0]  rd_start;
   logic [TIME_BITS-1:0]  rd_latest;
   logic [COUNT_BITS-1:0] rd_count;
   logic [TIME_BITS-1:0]  rd_longest;
   logic                  rd_level;
   logic [TIME_BITS-1:0]  since;
   logic [TIME_BITS-1:0]  duration;
   logic                  quiet_hit;
   logic [COUNT_BITS-1:0] count_next;
   logic                  out_free;
   logic                  out_load;
   logic                  out_last;
   logic                  wr_start;
   logic                  wr_edge;
   logic                  wr_close;
   logic                  wr_longest;

   // One channel is addressed per cycle: the edge channel, then the scan.
   assign addr       = (state_ff == ST_EDGE) ? IDX_BITS'(head_item.channel) : idx_ff;
   assign rd_start   = start_ff[addr];
   assign rd_latest  = latest_ff[addr];
   assign rd_count   = count_ff[addr];
   assign rd_longest = longest_ff[addr];
   assign rd_level   = level_ff[addr];

   // Time differences wrap modulo the timestamp width.
   assign since      = head_item.now - rd_latest;
   assign duration   = rd_latest - rd_start;
   assign quiet_hit  = (rd_count != '0) && (since >= TIME_BITS'(quiet_time));
   assign count_next = (rd_count == '1) ? rd_count : rd_count + 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_ready;

   // Sequencer: edge update, channel scan, then release of the held report.
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      head_pop      = 1'b0;
      out_load      = 1'b0;
      out_last      = 1'b0;
      wr_start      = 1'b0;
      wr_edge       = 1'b0;
      wr_close      = 1'b0;
      wr_longest    = 1'b0;
      unique case (state_ff)
         ST_EDGE: begin
            if (head_valid) begin
               if (head_item.edge_en) begin
                  wr_edge          = 1'b1;
                  wr_start         = (rd_count == '0);
                  pend_in.kind     = REPORT_EDGE;
                  pend_in.channel  = head_item.channel;
                  pend_in.level    = head_item.level;
                  pend_in.gap      = (rd_count == '0) ? '0 : since;
                  pend_in.count    = count_next;
                  pend_in.burst    = '0;
                  pend_in.longest  = '0;
                  pend_valid_in    = 1'b1;
               end
               idx_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (quiet_hit && pend_valid_ff && !out_free) begin
               // Wait until the held report can move to the output.
               state_in = ST_SCAN;
            end else begin
               if (quiet_hit) begin
                  out_load        = pend_valid_ff;
                  wr_close        = 1'b1;
                  wr_longest      = (duration > rd_longest);
                  pend_in.kind    = REPORT_CLOSED;
                  pend_in.channel = CHAN_BITS'(idx_ff);
                  pend_in.level   = rd_level;
                  pend_in.gap     = '0;
                  pend_in.count   = rd_count;
                  pend_in.burst   = duration;
                  pend_in.longest = (duration > rd_longest) ? duration : rd_longest;
                  pend_valid_in   = 1'b1;
               end
               if (idx_ff == IDX_BITS'(CHANNELS - 1)) begin
                  state_in = ST_FLUSH;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               head_pop = 1'b1;
               state_in = ST_EDGE;
            end else if (out_free) begin
               out_load      = 1'b1;
               out_last      = 1'b1;
               pend_valid_in = 1'b0;
               head_pop      = 1'b1;
               state_in      = ST_EDGE;
            end
         end
         default: begin
            state_in = ST_EDGE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_EDGE;
         idx_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         pend_valid_ff <= pend_valid_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Held report and output register.
   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      if (out_load) begin
         rsp_report_ff <= pend_ff;
         rsp_last_ff   <= out_last;
      end
   end

   // Burst state; reset closes every burst.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            start_ff[i]   <= '0;
            latest_ff[i]  <= '0;
            count_ff[i]   <= '0;
            longest_ff[i] <= '0;
            level_ff[i]   <= 1'b0;
         end
      end else begin
         if (wr_start) begin
            start_ff[addr] <= head_item.now;
         end
         if (wr_edge) begin
            latest_ff[addr] <= head_item.now;
            level_ff[addr]  <= head_item.level;
            count_ff[addr]  <= count_next;
         end
         if (wr_close) begin
            count_ff[addr] <= '0;
         end
         if (wr_longest) begin
            longest_ff[addr] <= duration;
         end
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_report = rsp_report_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

// ===== rtl/contact_bounce_burst_meter.sv =====
// ----------------------------------------------------------------------------
// Contact bounce burst meter
// Per-channel bounce measurement with quiet-time burst closing.
// ----------------------------------------------------------------------------
// Each item passes through the back end in steps: the edge update, the quiet
// scan over every channel, and the release of the final report. The scan
// visits one channel per cycle, unless it waits as below, through the single
// port of the per-channel state. Up to two items wait in the input queue.
// When a channel closes while an earlier report of the same item is still
// held back, the scan waits on that channel for as long as the output
// register stays full. The release cycle waits the same way for a free
// output register.
// An edge on a channel yields its edge report first, then every burst that
// has been quiet for quiet_time_us closes in ascending channel order, with
// rsp_last marking the final report of the item.
// ----------------------------------------------------------------------------
module contact_bounce_burst_meter
   import cbbm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_kind,
   input  logic [CHAN_BITS-1:0]  req_channel,
   input  logic                  req_edge_level,
   input  logic [TIME_BITS-1:0]  req_now_us,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_report_kind,
   output logic [CHAN_BITS-1:0]  rsp_report_channel,
   output logic                  rsp_line_level,
   output logic [TIME_BITS-1:0]  rsp_gap_us,
   output logic [COUNT_BITS-1:0] rsp_edge_count,
   output logic [TIME_BITS-1:0]  rsp_burst_us,
   output logic [TIME_BITS-1:0]  rsp_longest_us,
   output logic                  rsp_last,
   input  logic                  csr_wr_en,
   input  logic [QUIET_BITS-1:0] csr_wr_data
);

   logic [QUIET_BITS-1:0] quiet_ff;
   logic                  head_valid;
   item_type              head_item;
   logic                  head_pop;
   report_type            report;

   // Quiet time register.
   always_ff @(posedge clock) begin
      if (reset) begin
         quiet_ff <= QUIET_RESET;
      end else if (csr_wr_en) begin
         quiet_ff <= csr_wr_data;
      end
   end

   cbbm_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_channel    (req_channel),
      .req_edge_level (req_edge_level),
      .req_now_us     (req_now_us),
      .head_valid     (head_valid),
      .head_item      (head_item),
      .head_pop       (head_pop)
   );

   cbbm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .quiet_time (quiet_ff),
      .head_valid (head_valid),
      .head_item  (head_item),
      .head_pop   (head_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_report (report),
      .rsp_last   (rsp_last)
   );

   // Report fields onto their ports.
   assign rsp_report_kind    = report.kind;
   assign rsp_report_channel = report.channel;
   assign rsp_line_level     = report.level;
   assign rsp_gap_us         = report.gap;
   assign rsp_edge_count     = report.count;
   assign rsp_burst_us       = report.burst;
   assign rsp_longest_us     = report.longest;

endmodule

// ===== test/tb_contact_bounce_burst_meter.sv =====
// ----------------------------------------------------------------------------
// Contact bounce burst meter testbench
// Sends edge and tick items over the request channel and predicts every
// edge and burst-closed report in a behavioral model of the meter. A short
// table of directed items comes first, with hand-checked reports where they
// are obvious. Random phases with different quiet times and idle patterns
// follow. Each report is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_contact_bounce_burst_meter
   import cbbm_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // Cycles allowed after the last report for items that give none.
   localparam int SETTLE_CYCLES = 48;
   localparam int TIMEOUT_NS    = 40_000_000;
   localparam int REPORT_LIMIT  = 50;
   localparam int RANDOM_ITEMS  = 500;
   localparam logic [QUIET_BITS-1:0] QUIET_MAX = '1;

   // One report as it leaves the block.
   typedef struct packed {
      logic                  kind;
      logic [CHAN_BITS-1:0]  channel;
      logic                  level;
      logic [TIME_BITS-1:0]  gap;
      logic [COUNT_BITS-1:0] count;
      logic [TIME_BITS-1:0]  burst;
      logic [TIME_BITS-1:0]  longest;
      logic                  last;
   } meter_report_type;

   // One row of stimulus: an item, or a new quiet time.
   typedef struct {
      logic                  set_quiet;
      logic [QUIET_BITS-1:0] quiet;
      logic                  kind;
      logic [CHAN_BITS-1:0]  channel;
      logic                  level;
      logic [TIME_BITS-1:0]  now;
      logic                  typed;
      meter_report_type      exp;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_kind = 1'b0;
   logic [CHAN_BITS-1:0]  req_channel = '0;
   logic                  req_edge_level = 1'b0;
   logic [TIME_BITS-1:0]  req_now_us = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_report_kind;
   logic [CHAN_BITS-1:0]  rsp_report_channel;
   logic                  rsp_line_level;
   logic [TIME_BITS-1:0]  rsp_gap_us;
   logic [COUNT_BITS-1:0] rsp_edge_count;
   logic [TIME_BITS-1:0]  rsp_burst_us;
   logic [TIME_BITS-1:0]  rsp_longest_us;
   logic                  rsp_last;
   logic                  csr_wr_en = 1'b0;
   logic [QUIET_BITS-1:0] csr_wr_data = '0;

   // Shadow state of the meter, per channel.
   logic [QUIET_BITS-1:0] quiet_us = QUIET_RESET;
   logic [TIME_BITS-1:0]  open_start [CHANNELS];
   logic [TIME_BITS-1:0]  open_latest [CHANNELS];
   logic [COUNT_BITS-1:0] open_count [CHANNELS];
   logic [TIME_BITS-1:0]  longest_closed [CHANNELS];
   logic                  open_level [CHANNELS];

   meter_report_type step_reports[$];
   meter_report_type pending_reports[$];
   stim_row_type     directed[$];
   logic [TIME_BITS-1:0] wall_us;
   int send_idle_pct = 22;
   int recv_idle_pct = 49;
   int mismatch_count = 0;

   contact_bounce_burst_meter u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_channel        (req_channel),
      .req_edge_level     (req_edge_level),
      .req_now_us         (req_now_us),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_report_kind    (rsp_report_kind),
      .rsp_report_channel (rsp_report_channel),
      .rsp_line_level     (rsp_line_level),
      .rsp_gap_us         (rsp_gap_us),
      .rsp_edge_count     (rsp_edge_count),
      .rsp_burst_us       (rsp_burst_us),
      .rsp_longest_us     (rsp_longest_us),
      .rsp_last           (rsp_last),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Works out the reports of one item into step_reports and updates the
   // shadow state.
   task automatic predict_reports(input logic kind, input logic [CHAN_BITS-1:0] ch,
                                  input logic lvl, input logic [TIME_BITS-1:0] now);
      meter_report_type rep;
      logic [TIME_BITS-1:0] age;
      logic [TIME_BITS-1:0] span;
      step_reports.delete();
      // Edge update; a channel index past the last channel is dropped.
      if (kind == KIND_EDGE && ch < CHANNELS) begin
         rep = '0;
         rep.kind = REPORT_EDGE;
         rep.channel = ch;
         rep.level = lvl;
         if (open_count[ch] != '0) begin
            rep.gap = now - open_latest[ch];
         end else begin
            open_start[ch] = now;
         end
         if (open_count[ch] != '1) begin
            open_count[ch] = open_count[ch] + 1'b1;
         end
         open_latest[ch] = now;
         open_level[ch] = lvl;
         rep.count = open_count[ch];
         step_reports.push_back(rep);
      end
      // Quiet scan in ascending channel order, with modular time.
      for (int i = 0; i < CHANNELS; i++) begin
         age = now - open_latest[i];
         if (open_count[i] != '0 && age >= TIME_BITS'(quiet_us)) begin
            span = open_latest[i] - open_start[i];
            if (span > longest_closed[i]) begin
               longest_closed[i] = span;
            end
            rep = '0;
            rep.kind = REPORT_CLOSED;
            rep.channel = CHAN_BITS'(i);
            rep.level = open_level[i];
            rep.count = open_count[i];
            rep.burst = span;
            rep.longest = longest_closed[i];
            step_reports.push_back(rep);
            open_count[i] = '0;
         end
      end
      if (step_reports.size() > 0) begin
         rep = step_reports.pop_back();
         rep.last = 1'b1;
         step_reports.push_back(rep);
      end
   endtask

   function automatic stim_row_type item_row(input logic kind, input logic [CHAN_BITS-1:0] ch,
                                             input logic lvl, input logic [TIME_BITS-1:0] now);
      stim_row_type r;
      r.set_quiet = 1'b0;
      r.quiet = '0;
      r.kind = kind;
      r.channel = ch;
      r.level = lvl;
      r.now = now;
      r.typed = 1'b0;
      r.exp = '0;
      return r;
   endfunction

   // An item whose single report is written out by hand.
   function automatic stim_row_type checked_row(input logic kind,
                                                input logic [CHAN_BITS-1:0] ch,
                                                input logic lvl,
                                                input logic [TIME_BITS-1:0] now,
                                                input logic rkind,
                                                input logic [CHAN_BITS-1:0] rch,
                                                input logic rlvl,
                                                input logic [TIME_BITS-1:0] gap,
                                                input logic [COUNT_BITS-1:0] cnt,
                                                input logic [TIME_BITS-1:0] burst,
                                                input logic [TIME_BITS-1:0] longest);
      stim_row_type r;
      r = item_row(kind, ch, lvl, now);
      r.typed = 1'b1;
      r.exp = '{kind: rkind, channel: rch, level: rlvl, gap: gap, count: cnt,
                burst: burst, longest: longest, last: 1'b1};
      return r;
   endfunction

   function automatic stim_row_type quiet_row(input logic [QUIET_BITS-1:0] q);
      stim_row_type r;
      r = item_row(KIND_TICK, '0, 1'b0, '0);
      r.set_quiet = 1'b1;
      r.quiet = q;
      return r;
   endfunction

   // Offers one item, waits for its acceptance and queues its reports.
   task automatic send_item(input stim_row_type row);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= row.kind;
      req_channel <= row.channel;
      req_edge_level <= row.level;
      req_now_us <= row.now;
      do @(posedge clock); while (!req_ready);
      predict_reports(row.kind, row.channel, row.level, row.now);
      if (row.typed) begin
         pending_reports.push_back(row.exp);
      end else begin
         foreach (step_reports[j]) pending_reports.push_back(step_reports[j]);
      end
   endtask

   // Waits until every queued report has arrived, then waits out the settle time.
   task automatic drain_reports();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_quiet(input logic [QUIET_BITS-1:0] q);
      csr_wr_en <= 1'b1;
      csr_wr_data <= q;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      quiet_us = q;
   endtask

   // Random items: mostly bounce-sized steps, with steps around and past the
   // quiet time to close bursts, and some backward jumps and raw timestamps.
   task automatic run_random(input int count);
      int pick;
      logic [TIME_BITS-1:0] now;
      logic kind;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 6) begin
            now = TIME_BITS'({$urandom(), $urandom()});
         end else if (pick < 10) begin
            now = wall_us - TIME_BITS'($urandom_range(1, 1000));
         end else if (pick < 25) begin
            now = wall_us + TIME_BITS'(quiet_us) + TIME_BITS'($urandom_range(0, int'(quiet_us)));
         end else if (pick < 32) begin
            now = wall_us + TIME_BITS'(quiet_us) - TIME_BITS'($urandom_range(0, 1));
         end else begin
            now = wall_us + TIME_BITS'($urandom_range(0, int'(quiet_us >> 3)));
         end
         wall_us = now;
         kind = ($urandom_range(0, 99) < 20) ? KIND_TICK : KIND_EDGE;
         send_item(item_row(kind, CHAN_BITS'($urandom_range(0, CHANNELS - 1)),
                            1'(($urandom_range(0, 1))), now));
      end
   endtask

   // Report checker and receiver stalls.
   task automatic cmp_field(input string name, input logic [63:0] want, input logic [63:0] got);
      if (got !== want) begin
         // Further mismatches are counted but not printed.
         if (mismatch_count < REPORT_LIMIT) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         end
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      meter_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_reports.size() == 0) begin
            $error("report with none expected: kind %0d channel %0d",
                   rsp_report_kind, rsp_report_channel);
            mismatch_count++;
         end else begin
            want = pending_reports.pop_front();
            cmp_field("report_kind", 64'(want.kind), 64'(rsp_report_kind));
            cmp_field("report_channel", 64'(want.channel), 64'(rsp_report_channel));
            cmp_field("line_level", 64'(want.level), 64'(rsp_line_level));
            cmp_field("gap_us", 64'(want.gap), 64'(rsp_gap_us));
            cmp_field("edge_count", 64'(want.count), 64'(rsp_edge_count));
            cmp_field("burst_us", 64'(want.burst), 64'(rsp_burst_us));
            cmp_field("longest_us", 64'(want.longest), 64'(rsp_longest_us));
            cmp_field("last", 64'(want.last), 64'(rsp_last));
         end
      end
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Stimulus.
   initial begin
      for (int i = 0; i < CHANNELS; i++) begin
         open_start[i] = '0;
         open_latest[i] = '0;
         open_count[i] = '0;
         longest_closed[i] = '0;
         open_level[i] = 1'b0;
      end

      // Reset quiet time: burst open, extend, close at exactly the quiet age.
      directed.push_back(checked_row(KIND_EDGE, 2'd0, 1'b1, 48'd0,
                                     REPORT_EDGE, 2'd0, 1'b1, 48'd0, 16'd1, 48'd0, 48'd0));
      directed.push_back(checked_row(KIND_EDGE, 2'd0, 1'b0, 48'd100,
                                     REPORT_EDGE, 2'd0, 1'b0, 48'd100, 16'd2, 48'd0, 48'd0));
      directed.push_back(checked_row(KIND_EDGE, 2'd3, 1'b1, 48'd200,
                                     REPORT_EDGE, 2'd3, 1'b1, 48'd0, 16'd1, 48'd0, 48'd0));
      directed.push_back(item_row(KIND_TICK, 2'd2, 1'b1, 48'd499999));
      directed.push_back(checked_row(KIND_TICK, 2'd0, 1'b0, 48'd500100,
                                     REPORT_CLOSED, 2'd0, 1'b0, 48'd0, 16'd2, 48'd100, 48'd100));
      directed.push_back(checked_row(KIND_TICK, 2'd0, 1'b0, 48'd500200,
                                     REPORT_CLOSED, 2'd3, 1'b1, 48'd0, 16'd1, 48'd0, 48'd0));
      // Time wraps past the top, then goes backward.
      directed.push_back(checked_row(KIND_EDGE, 2'd1, 1'b1, 48'hFFFF_FFFF_FFFF,
                                     REPORT_EDGE, 2'd1, 1'b1, 48'd0, 16'd1, 48'd0, 48'd0));
      directed.push_back(checked_row(KIND_EDGE, 2'd1, 1'b0, 48'd5,
                                     REPORT_EDGE, 2'd1, 1'b0, 48'd6, 16'd2, 48'd0, 48'd0));
      directed.push_back(item_row(KIND_EDGE, 2'd2, 1'b1, 48'd1000));
      directed.push_back(item_row(KIND_EDGE, 2'd1, 1'b1, 48'd0));
      directed.push_back(item_row(KIND_TICK, 2'd3, 1'b1, 48'hAAAA_AAAA_AAAA));
      // Largest quiet time.
      directed.push_back(quiet_row(QUIET_MAX));
      directed.push_back(checked_row(KIND_EDGE, 2'd2, 1'b0, 48'd1_000_000,
                                     REPORT_EDGE, 2'd2, 1'b0, 48'd0, 16'd1, 48'd0, 48'd0));
      directed.push_back(checked_row(KIND_EDGE, 2'd2, 1'b1, 48'd1_000_000,
                                     REPORT_EDGE, 2'd2, 1'b1, 48'd0, 16'd2, 48'd0, 48'd0));
      directed.push_back(item_row(KIND_TICK, 2'd0, 1'b0, 48'd17_777_214));
      directed.push_back(item_row(KIND_TICK, 2'd0, 1'b0, 48'd17_777_215));
      directed.push_back(item_row(KIND_EDGE, 2'd0, 1'b1, 48'd20_000_000));
      directed.push_back(item_row(KIND_EDGE, 2'd1, 1'b0, 48'd20_000_000));
      directed.push_back(item_row(KIND_EDGE, 2'd2, 1'b1, 48'd20_000_000));
      directed.push_back(item_row(KIND_EDGE, 2'd3, 1'b0, 48'd20_000_000));
      // Zero quiet time: one edge closes all four open bursts at once.
      directed.push_back(quiet_row('0));
      directed.push_back(item_row(KIND_EDGE, 2'd1, 1'b1, 48'd20_000_010));
      directed.push_back(item_row(KIND_EDGE, 2'd3, 1'b0, 48'h5555_5555_5555));
      directed.push_back(item_row(KIND_TICK, 2'd2, 1'b0, 48'h5555_5555_5556));
      // Smallest nonzero quiet time.
      directed.push_back(quiet_row(24'd1));
      directed.push_back(checked_row(KIND_EDGE, 2'd0, 1'b0, 48'd50,
                                     REPORT_EDGE, 2'd0, 1'b0, 48'd0, 16'd1, 48'd0, 48'd0));
      directed.push_back(item_row(KIND_EDGE, 2'd0, 1'b1, 48'd50));
      directed.push_back(item_row(KIND_TICK, 2'd1, 1'b1, 48'd51));

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[k]) begin
         if (directed[k].set_quiet) begin
            drain_reports();
            write_quiet(directed[k].quiet);
         end else begin
            send_item(directed[k]);
         end
      end
      wall_us = 48'd51;

      // Random phase with a moderate quiet time.
      drain_reports();
      write_quiet(QUIET_BITS'($urandom_range(2, 5000)));
      run_random(RANDOM_ITEMS / 3);

      // Idle patterns swapped, quiet time of one microsecond.
      drain_reports();
      send_idle_pct = 49;
      recv_idle_pct = 22;
      write_quiet(24'd1);
      run_random(RANDOM_ITEMS / 3);

      // No idling, any nonzero quiet time.
      drain_reports();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_quiet(QUIET_BITS'($urandom_range(1, int'(QUIET_MAX))));
      run_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

      drain_reports();
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #(TIMEOUT_NS);
      $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/cbbm_pkg.sv
rtl/cbbm_front.sv
rtl/cbbm_back.sv
rtl/contact_bounce_burst_meter.sv
test/tb_contact_bounce_burst_meter.sv
